/* src/afu_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and constant tables for the activation function unit
package afu_pkg;

    typedef enum logic [1:0] {
        MODE_RELU    = 2'd0,
        MODE_SIGMOID = 2'd1,
        MODE_TANH    = 2'd2,
        MODE_PRELU   = 2'd3
    } t_act_mode;

    localparam logic CMD_ACTIVATE    = 1'b0;
    localparam logic CMD_WRITE_SLOPE = 1'b1;

    // register index as decoded from paddr[2]
    localparam logic REG_ACT_MODE     = 1'b0;
    localparam logic REG_SLOPE_SHARED = 1'b1;

    localparam int CH_W   = 10;
    localparam int CH_MAX = 1 << CH_W;
    localparam int X_W    = 16;
    localparam int YQ_W   = 12;
    localparam int TAB_W  = 6;

    // exp values in unsigned fixed point, 1.0 = 2^F_BITS
    localparam int F_BITS = 52;
    localparam int F_W    = F_BITS + 1;
    localparam int SPLIT  = F_BITS / 2;

    // rounding search over the result count
    localparam int C_W = 9;
    localparam logic [9:0]  SIG_LIMIT  = 10'd128;
    localparam logic [9:0]  TANH_LIMIT = 10'd256;
    localparam logic [10:0] SIG_A0     = 11'd257;
    localparam logic [10:0] SIG_B0     = 11'd255;
    localparam logic [10:0] TANH_A0    = 11'd513;
    localparam logic [10:0] TANH_B0    = 11'd511;
    localparam logic [15:0] SIG_MID    = 16'd128;

    typedef struct packed {
        t_act_mode        mode;
        logic             neg;
        logic             full;
        logic [F_W-1:0]   f;
        logic [C_W-1:0]   c;
        logic [X_W-1:0]   pre_y;
        logic             pre_sat;
    } t_srch;

    // exp(-1/256) with 62 fraction bits, by its series
    localparam int EXP_FRAC = 62;
    localparam logic [63:0] EXP_ONE = 64'd1 << EXP_FRAC;
    localparam logic [63:0] EXP_STEP = EXP_ONE - (EXP_ONE >> 8) + (EXP_ONE >> 17)
        - (EXP_ONE >> 24) / 6 + (EXP_ONE >> 32) / 24
        - (EXP_ONE >> 40) / 120 + (EXP_ONE >> 48) / 720;

    // exp(-n/256) by square and multiply, evaluated at elaboration
    function automatic logic [F_W-1:0] exp_neg_q(input logic [YQ_W-1:0] n);
        logic [63:0]  acc;
        logic [63:0]  base;
        logic [127:0] prod;
        acc  = EXP_ONE;
        base = EXP_STEP;
        for (int i = 0; i < YQ_W; i++) begin
            if (n[i]) begin
                prod = 128'(acc) * 128'(base);
                acc  = prod[EXP_FRAC+63:EXP_FRAC];
            end
            prod = 128'(base) * 128'(base);
            base = prod[EXP_FRAC+63:EXP_FRAC];
        end
        return acc[EXP_FRAC:EXP_FRAC-F_BITS];
    endfunction

endpackage

/* src/afu_if.sv */
`timescale 1ns / 1ps
// handshake channels for sample items and result items
interface afu_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic signed [afu_pkg::X_W-1:0]   sample;
    logic        [afu_pkg::CH_W-1:0]  channel_index;
    logic signed [afu_pkg::X_W-1:0]   slope_word;

    modport source (output valid, command, sample, channel_index, slope_word, input ready);
    modport sink (input valid, command, sample, channel_index, slope_word, output ready);
endinterface

interface afu_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [afu_pkg::X_W-1:0]   activated;
    logic                             saturated;

    modport source (output valid, activated, saturated, input ready);
    modport sink (input valid, activated, saturated, output ready);
endinterface

/* src/activation_function_unit.sv */
`timescale 1ns / 1ps
// activation function unit: relu, sigmoid, tanh and per-channel prelu on Q8.8 samples
// throughput: one item per cycle unless the output stalls; 4 front stages, 9 search steps, output register
// each stage holds only on its own backpressure, so bubbles close up under a stall
// reset (i_rst_n low, synchronous) clears all valid bits and sets relu, unshared slopes
// the slope table is not cleared and must be written before a prelu item reads it
module activation_function_unit #(
    parameter int CHANNELS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    afu_in_if.sink      i_in,
    afu_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = (CHANNELS < afu_pkg::CH_MAX) ? CHANNELS : afu_pkg::CH_MAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NTAB  = 1 << afu_pkg::TAB_W;
    localparam int FW    = afu_pkg::F_W;
    localparam int SP    = afu_pkg::SPLIT;
    localparam int NSTEP = afu_pkg::C_W;

    // configuration registers
    afu_pkg::t_act_mode r_act_mode;
    logic               r_slope_shared;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode     <= afu_pkg::MODE_RELU;
            r_slope_shared <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                afu_pkg::REG_ACT_MODE:     r_act_mode     <= afu_pkg::t_act_mode'(pwdata[1:0]);
                afu_pkg::REG_SLOPE_SHARED: r_slope_shared <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            afu_pkg::REG_ACT_MODE:     prdata = {30'd0, r_act_mode};
            afu_pkg::REG_SLOPE_SHARED: prdata = {31'd0, r_slope_shared};
            default:                   prdata = 32'd0;
        endcase
    end

    // stage enables
    logic w_en1, w_en2, w_en3, w_en4, w_en_out;
    logic w_accept;

    // stage 1: capture, magnitude, slope read
    logic                         r1_vld;
    afu_pkg::t_act_mode           r1_mode;
    logic signed [15:0]           r1_x;
    logic                         r1_neg;
    logic                         r1_full;
    logic [afu_pkg::YQ_W-1:0]     r1_yq;
    logic                         r1_slope_ok;
    logic [16:0]                  w_mag;
    logic                         w_full;
    logic [afu_pkg::YQ_W-1:0]     w_yq;
    logic                         w_ch_ok;
    logic [15:0]                  w_slope_raw;
    logic signed [15:0]           w_slope;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = w_en1;
    assign w_mag = i_in.sample[15] ? (17'd0 - {i_in.sample[15], i_in.sample})
                                   : {1'b0, i_in.sample};
    assign w_ch_ok = 32'(i_in.channel_index) < 32'(CHANNELS);

    always_comb begin
        if (r_act_mode == afu_pkg::MODE_TANH) begin
            w_full = |w_mag[16:11];
            w_yq   = {w_mag[10:0], 1'b0};
        end else begin
            w_full = |w_mag[16:12];
            w_yq   = w_mag[11:0];
        end
    end

    afu_slope_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_slope_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_in.command == afu_pkg::CMD_WRITE_SLOPE) && w_ch_ok),
        .i_waddr (i_in.channel_index[AW-1:0]),
        .i_wdata (i_in.slope_word),
        .i_re    (w_accept && (i_in.command == afu_pkg::CMD_ACTIVATE)),
        .i_raddr (r_slope_shared ? '0 : i_in.channel_index[AW-1:0]),
        .o_rdata (w_slope_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en1) begin
            r1_vld <= i_in.valid && (i_in.command == afu_pkg::CMD_ACTIVATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_mode     <= r_act_mode;
            r1_x        <= i_in.sample;
            r1_neg      <= i_in.sample[15];
            r1_full     <= w_full;
            r1_yq       <= w_yq;
            r1_slope_ok <= r_slope_shared || w_ch_ok;
        end
    end

    // stage 2: exp table lookups and prelu product
    logic [FW-1:0]          w_ehi [NTAB];
    logic [FW-1:0]          w_elo [NTAB];
    logic                   r2_vld;
    afu_pkg::t_act_mode     r2_mode;
    logic signed [15:0]     r2_x;
    logic                   r2_neg;
    logic                   r2_full;
    logic [FW-1:0]          r2_ehi;
    logic [FW-1:0]          r2_elo;
    logic signed [31:0]     r2_prod;

    for (genvar g = 0; g < NTAB; g++) begin : g_exp_tab
        localparam logic [FW-1:0] EHI_V =
            afu_pkg::exp_neg_q(afu_pkg::YQ_W'(g << afu_pkg::TAB_W));
        localparam logic [FW-1:0] ELO_V = afu_pkg::exp_neg_q(afu_pkg::YQ_W'(g));
        assign w_ehi[g] = EHI_V;
        assign w_elo[g] = ELO_V;
    end

    assign w_slope = r1_slope_ok ? $signed(w_slope_raw) : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_mode <= r1_mode;
            r2_x    <= r1_x;
            r2_neg  <= r1_neg;
            r2_full <= r1_full;
            r2_ehi  <= w_ehi[r1_yq[afu_pkg::YQ_W-1:afu_pkg::TAB_W]];
            r2_elo  <= w_elo[r1_yq[afu_pkg::TAB_W-1:0]];
            r2_prod <= 32'(r1_x) * 32'(w_slope);
        end
    end

    // stage 3: partial products of the exp and prelu rounding
    logic                   r3_vld;
    afu_pkg::t_act_mode     r3_mode;
    logic                   r3_neg;
    logic                   r3_full;
    logic [2*(FW-SP)-1:0]   r3_pp_hh;
    logic [FW-1:0]          r3_pp_hl;
    logic [FW-1:0]          r3_pp_lh;
    logic [2*SP-1:0]        r3_pp_ll;
    logic [15:0]            r3_pre_y;
    logic                   r3_pre_sat;
    logic                   w_xpos;
    logic [31:0]            w_pm;
    logic [31:0]            w_rsum;
    logic [19:0]            w_rmag;
    logic                   w_psat;
    logic [15:0]            w_prelu_y;
    logic [15:0]            n3_pre_y;
    logic                   n3_pre_sat;

    assign w_xpos = !r2_x[15] && (r2_x != 16'sd0);
    assign w_pm   = r2_prod[31] ? (32'd0 - r2_prod) : r2_prod;
    assign w_rsum = w_pm + 32'd2048;
    assign w_rmag = w_rsum[31:12];
    assign w_psat = r2_prod[31] ? (w_rmag > 20'd32768) : (w_rmag > 20'd32767);

    always_comb begin
        if (w_psat) begin
            w_prelu_y = r2_prod[31] ? 16'h8000 : 16'h7fff;
        end else if (r2_prod[31]) begin
            w_prelu_y = 16'd0 - w_rmag[15:0];
        end else begin
            w_prelu_y = w_rmag[15:0];
        end
    end

    always_comb begin
        n3_pre_y   = 16'd0;
        n3_pre_sat = 1'b0;
        if (w_xpos) begin
            n3_pre_y = r2_x;
        end else if (r2_mode == afu_pkg::MODE_PRELU) begin
            n3_pre_y   = w_prelu_y;
            n3_pre_sat = w_psat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en3) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_mode    <= r2_mode;
            r3_neg     <= r2_neg;
            r3_full    <= r2_full;
            r3_pp_hh   <= (2*(FW-SP))'(r2_ehi[FW-1:SP]) * (2*(FW-SP))'(r2_elo[FW-1:SP]);
            r3_pp_hl   <= FW'(r2_ehi[FW-1:SP]) * FW'(r2_elo[SP-1:0]);
            r3_pp_lh   <= FW'(r2_ehi[SP-1:0]) * FW'(r2_elo[FW-1:SP]);
            r3_pp_ll   <= (2*SP)'(r2_ehi[SP-1:0]) * (2*SP)'(r2_elo[SP-1:0]);
            r3_pre_y   <= n3_pre_y;
            r3_pre_sat <= n3_pre_sat;
        end
    end

    // stage 4: exp product sum
    logic           r4_vld;
    afu_pkg::t_srch r4_stage;
    afu_pkg::t_srch n4_stage;
    logic [FW+1:0]  w_mid;
    logic [FW+1:0]  w_fsum;

    assign w_mid  = (FW+2)'(r3_pp_hl) + (FW+2)'(r3_pp_lh) + (FW+2)'(r3_pp_ll[2*SP-1:SP]);
    assign w_fsum = (FW+2)'(r3_pp_hh) + (FW+2)'(w_mid[FW+1:SP]);

    always_comb begin
        n4_stage.mode    = r3_mode;
        n4_stage.neg     = r3_neg;
        n4_stage.full    = r3_full;
        n4_stage.f       = w_fsum[FW-1:0];
        n4_stage.c       = '0;
        n4_stage.pre_y   = r3_pre_y;
        n4_stage.pre_sat = r3_pre_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en4) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_stage <= n4_stage;
        end
    end

    // stages 5 to 13: one result bit per step, most significant first
    afu_pkg::t_srch w_sst  [NSTEP+1];
    logic           w_svld [NSTEP+1];
    logic           w_sen  [NSTEP];

    assign w_sst[0]  = r4_stage;
    assign w_svld[0] = r4_vld;

    for (genvar k = 0; k < NSTEP; k++) begin : g_search
        afu_search_step #(
            .BIT (NSTEP - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_sen[k]),
            .i_valid (w_svld[k]),
            .i_stage (w_sst[k]),
            .o_valid (w_svld[k+1]),
            .o_stage (w_sst[k+1])
        );
        if (k < NSTEP - 1) begin : g_mid
            assign w_sen[k] = !w_svld[k+1] || w_sen[k+1];
        end else begin : g_last
            assign w_sen[k] = !w_svld[k+1] || w_en_out;
        end
    end

    // stage 14: output register
    logic                   r_out_vld;
    afu_pkg::t_act_mode     r_out_mode;
    logic [15:0]            r_out_y;
    logic                   r_out_sat;
    logic [15:0]            w_cnt;
    logic [15:0]            n_out_y;
    afu_pkg::t_srch         w_fin;

    assign w_fin = w_sst[NSTEP];

    always_comb begin
        w_cnt   = 16'(w_fin.c);
        n_out_y = w_fin.pre_y;
        case (w_fin.mode)
            afu_pkg::MODE_SIGMOID: begin
                if (w_fin.full) begin
                    w_cnt = 16'(afu_pkg::SIG_LIMIT);
                end
                n_out_y = w_fin.neg ? (afu_pkg::SIG_MID - w_cnt) : (afu_pkg::SIG_MID + w_cnt);
            end
            afu_pkg::MODE_TANH: begin
                if (w_fin.full) begin
                    w_cnt = 16'(afu_pkg::TANH_LIMIT);
                end
                n_out_y = w_fin.neg ? (16'd0 - w_cnt) : w_cnt;
            end
            default: n_out_y = w_fin.pre_y;
        endcase
    end

    assign w_en_out = !r_out_vld || o_res.ready;
    assign w_en4    = !r4_vld || w_sen[0];
    assign w_en3    = !r3_vld || w_en4;
    assign w_en2    = !r2_vld || w_en3;
    assign w_en1    = !r1_vld || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en_out) begin
            r_out_vld <= w_svld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_mode <= w_fin.mode;
            r_out_y    <= n_out_y;
            r_out_sat  <= w_fin.pre_sat;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.activated = r_out_y;
    assign o_res.saturated = r_out_sat;

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |-> ((r_out_y == 16'h7fff) || (r_out_y == 16'h8000)))
        else $error("saturated result is not a range limit");

    a_sat_prelu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_sat) |-> (r_out_mode == afu_pkg::MODE_PRELU))
        else $error("saturation flagged outside prelu");

    a_tanh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_mode == afu_pkg::MODE_TANH))
            |-> (($signed(r_out_y) >= -16'sd256) && ($signed(r_out_y) <= 16'sd256)))
        else $error("tanh result out of range");

    a_sigmoid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_mode == afu_pkg::MODE_SIGMOID))
            |-> (($signed(r_out_y) >= 16'sd0) && ($signed(r_out_y) <= 16'sd256)))
        else $error("sigmoid result out of range");

    a_write_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.command == afu_pkg::CMD_WRITE_SLOPE)) |=> !r1_vld)
        else $error("slope write entered the result pipeline");

endmodule

/* src/afu_slope_ram.sv */
`timescale 1ns / 1ps
// prelu slope table, one write port and one registered read port
module afu_slope_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [afu_pkg::X_W-1:0]   i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [afu_pkg::X_W-1:0]   o_rdata
);

    logic [afu_pkg::X_W-1:0] r_mem [DEPTH];
    logic [afu_pkg::X_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/afu_search_step.sv */
`timescale 1ns / 1ps
// one registered step of the rounding search for sigmoid and tanh
module afu_search_step #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  afu_pkg::t_srch  i_stage,
    output logic            o_valid,
    output afu_pkg::t_srch  o_stage
);

    localparam logic [9:0] STEP = 10'(1 << BIT);

    logic           r_vld;
    afu_pkg::t_srch r_stage;
    afu_pkg::t_srch n_stage;
    logic [9:0]     w_limit;
    logic [10:0]    w_a0;
    logic [10:0]    w_b0;
    logic [9:0]     w_try;
    logic [9:0]     w_j;
    logic [10:0]    w_a;
    logic [10:0]    w_b;
    logic [63:0]    w_lhs;
    logic [63:0]    w_rhs;

    always_comb begin
        if (i_stage.mode == afu_pkg::MODE_TANH) begin
            w_limit = afu_pkg::TANH_LIMIT;
            w_a0    = afu_pkg::TANH_A0;
            w_b0    = afu_pkg::TANH_B0;
        end else begin
            w_limit = afu_pkg::SIG_LIMIT;
            w_a0    = afu_pkg::SIG_A0;
            w_b0    = afu_pkg::SIG_B0;
        end
    end

    // level j holds when f * (a0 + 2j) <= (b0 - 2j)
    assign w_try = {1'b0, i_stage.c} + STEP;
    assign w_j   = w_try - 10'd1;
    assign w_a   = w_a0 + {w_j, 1'b0};
    assign w_b   = w_b0 - {w_j, 1'b0};
    assign w_lhs = 64'(i_stage.f) * 64'(w_a);
    assign w_rhs = 64'(w_b[8:0]) << afu_pkg::F_BITS;

    always_comb begin
        n_stage = i_stage;
        if ((w_try <= w_limit) && (w_lhs <= w_rhs)) begin
            n_stage.c = w_try[afu_pkg::C_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_vld;
    assign o_stage = r_stage;

endmodule
